/* design/cls_pkg.sv */
// Package with the shared types, state codes and status codes of the character literal scanner.
`timescale 1ns / 1ps

package cls_pkg;

  // Scan state codes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_OPEN  = 3'd1;
  localparam logic [2:0] MODE_ESC   = 3'd2;
  localparam logic [2:0] MODE_HEX1  = 3'd3;
  localparam logic [2:0] MODE_HEX2  = 3'd4;
  localparam logic [2:0] MODE_CLOSE = 3'd5;
  localparam logic [2:0] MODE_SKIP  = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNTERMINATED = 3'd1;
  localparam logic [2:0] ST_EMPTY        = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE   = 3'd3;
  localparam logic [2:0] ST_BAD_HEX      = 3'd4;
  localparam logic [2:0] ST_UNKNOWN_ESC  = 3'd5;
  localparam logic [2:0] ST_MULTICHAR    = 3'd6;
  localparam logic [2:0] ST_NO_CLOSE     = 3'd7;

  // Character constants.
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } cls_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] char_value;
  } cls_rsp_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] held;
    logic       emit;
    cls_rsp_t   rsp;
  } cls_step_t;

endpackage

/* design/cls_step.sv */
// Next-state and result logic of the scanner for one source byte.
`timescale 1ns / 1ps

module cls_step (
  input  logic [2:0]        mode_i,
  input  logic [7:0]        held_i,
  input  cls_pkg::cls_req_t req_i,
  output cls_pkg::cls_step_t step_o
);
  import cls_pkg::*;

  logic [7:0] b;
  logic       eoi;
  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic       hex_ok;
  logic [3:0] hex_val;

  assign b   = req_i.data_byte;
  assign eoi = req_i.end_of_input;

  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_lower = (b >= 8'h61) && (b <= 8'h66);
  assign is_upper = (b >= 8'h41) && (b <= 8'h46);
  assign hex_ok   = is_digit || is_lower || is_upper;
  // Letters a-f and A-F share the low nibble pattern 1..6, giving 10..15 after adding 9.
  assign hex_val  = is_digit ? b[3:0] : 4'(b[3:0] + 4'd9);

  always_comb begin
    logic       fin;
    logic [2:0] st;
    fin = 1'b0;
    st  = ST_OK;
    step_o.mode = mode_i;
    step_o.held = held_i;

    unique case (mode_i)
      MODE_OPEN: begin
        if (eoi) begin
          fin = 1'b1;
          st  = ST_UNTERMINATED;
        end else if (b == CH_QUOTE) begin
          fin = 1'b1;
          st  = ST_EMPTY;
        end else if (b == CH_BACKSLASH) begin
          step_o.mode = MODE_ESC;
        end else begin
          step_o.held = b;
          step_o.mode = MODE_CLOSE;
        end
      end
      MODE_ESC: begin
        if (eoi) begin
          fin = 1'b1;
          st  = ST_INCOMPLETE;
        end else begin
          unique case (b)
            CH_N: begin
              step_o.held = CH_NEWLINE;
              step_o.mode = MODE_CLOSE;
            end
            CH_T: begin
              step_o.held = CH_TAB;
              step_o.mode = MODE_CLOSE;
            end
            CH_BACKSLASH: begin
              step_o.held = CH_BACKSLASH;
              step_o.mode = MODE_CLOSE;
            end
            CH_QUOTE: begin
              step_o.held = CH_QUOTE;
              step_o.mode = MODE_CLOSE;
            end
            CH_X: begin
              step_o.mode = MODE_HEX1;
            end
            default: begin
              fin = 1'b1;
              st  = ST_UNKNOWN_ESC;
            end
          endcase
        end
      end
      MODE_HEX1: begin
        if (eoi || !hex_ok) begin
          fin = 1'b1;
          st  = ST_BAD_HEX;
        end else begin
          step_o.held = {4'd0, hex_val};
          step_o.mode = MODE_HEX2;
        end
      end
      MODE_HEX2, MODE_CLOSE: begin
        if ((mode_i == MODE_HEX2) && !eoi && hex_ok) begin
          step_o.held = {held_i[3:0], hex_val};
          step_o.mode = MODE_CLOSE;
        end else if (eoi) begin
          fin = 1'b1;
          st  = ST_NO_CLOSE;
        end else if (b == CH_QUOTE) begin
          fin = 1'b1;
          st  = ST_OK;
        end else begin
          step_o.mode = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (eoi || (b == CH_QUOTE)) begin
          fin = 1'b1;
          st  = ST_MULTICHAR;
        end
      end
      default: begin
        // Idle, and the unused code, wait for an opening quote.
        if (!eoi && (b == CH_QUOTE)) begin
          step_o.mode = MODE_OPEN;
          step_o.held = 8'd0;
        end else begin
          step_o.mode = MODE_IDLE;
        end
      end
    endcase

    if (fin) begin
      step_o.mode = MODE_IDLE;
      step_o.held = 8'd0;
    end
    step_o.emit           = fin;
    step_o.rsp.status     = st;
    step_o.rsp.char_value = (st == ST_OK) ? held_i : 8'd0;
  end

endmodule

/* design/char_literal_scanner_core.sv */
// Top level of the character literal scanner: state registers and result register.
// A result appears in the output register in the cycle after the byte is accepted.
// Throughput: one byte per cycle while not stalled; next-state logic is combinational.
// A byte is accepted whenever the result register is empty or is drained in the same cycle.
// Reset (asynchronous, active low) returns the scanner to idle with no result pending.
`timescale 1ns / 1ps

module char_literal_scanner_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cls_pkg::cls_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cls_pkg::cls_rsp_t out_rsp_o
);
  import cls_pkg::*;

  logic [2:0] mode_q;
  logic [7:0] held_q;
  logic       out_valid_q;
  cls_rsp_t   out_rsp_q;
  cls_step_t  step;
  logic       accept;

  cls_step u_step (
    .mode_i (mode_q),
    .held_i (held_q),
    .req_i  (in_req_i),
    .step_o (step)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      held_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= step.mode;
        held_q      <= step.held;
        out_valid_q <= step.emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step.emit) begin
      out_rsp_q <= step.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* design/cls_checker.sv */
// Port-level checker for the character literal scanner, bound to the top level.
`timescale 1ns / 1ps

module cls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input cls_pkg::cls_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cls_pkg::cls_rsp_t out_rsp_o
);
  import cls_pkg::*;

  // A pending result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // A waiting request keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while stalled");

  // Only a successful literal carries a character value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |-> out_rsp_o.char_value == 8'd0)
    else $error("error result with nonzero character");

  // A new result only follows an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without a request");

  // The scanner never stalls input while no result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind char_literal_scanner_core cls_checker u_cls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

/* verif/char_literal_scanner_core_test.sv */
// Self-checking testbench for the character literal scanner core with a directed table and random literals.
`timescale 1ns / 1ps

module char_literal_scanner_core_test;
  import cls_pkg::*;

  localparam int LiveItemTarget = 1250;
  localparam int StallCycles    = 300;

  typedef struct {
    cls_req_t req;
    bit       typed;
    cls_rsp_t rsp;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  cls_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cls_rsp_t out_rsp_o;

  // Predicted scanner state, advanced once per accepted request.
  logic [2:0] scan_state = MODE_IDLE;
  logic [7:0] scan_held  = 8'h00;

  cls_rsp_t literal_q[$];
  dir_row_t dir_rows[$];
  int       err_count    = 0;
  int       req_count    = 0;
  int       live_items   = 0;
  int       results_seen = 0;
  int       burst_left   = 0;
  int       status_seen[8];

  char_literal_scanner_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cls_req_t mk_req(logic [7:0] b, logic eoi);
    cls_req_t r;
    r.data_byte    = b;
    r.end_of_input = eoi;
    return r;
  endfunction

  function automatic bit is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  // Letters in both cases carry their value in the low nibble offset by nine.
  function automatic logic [3:0] hex_nibble(logic [7:0] b);
    if (b <= 8'h39) return b[3:0];
    return b[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return 8'(8'h30 + d);
    if (d < 16) return 8'(8'h61 + d - 10);
    return 8'(8'h41 + d - 16);
  endfunction

  function automatic bit scan_literal(input cls_req_t r, output cls_rsp_t res);
    logic [7:0] b;
    logic       eoi;
    logic [2:0] st;
    bit         done;
    b    = r.data_byte;
    eoi  = r.end_of_input;
    st   = ST_OK;
    done = 1'b0;
    res  = '0;
    case (scan_state)
      MODE_OPEN: begin
        if (eoi) begin
          done = 1'b1;
          st   = ST_UNTERMINATED;
        end else if (b == CH_QUOTE) begin
          done = 1'b1;
          st   = ST_EMPTY;
        end else if (b == CH_BACKSLASH) begin
          scan_state = MODE_ESC;
        end else begin
          scan_held  = b;
          scan_state = MODE_CLOSE;
        end
      end
      MODE_ESC: begin
        if (eoi) begin
          done = 1'b1;
          st   = ST_INCOMPLETE;
        end else if (b == CH_X) begin
          scan_state = MODE_HEX1;
        end else if (b == CH_N || b == CH_T || b == CH_BACKSLASH || b == CH_QUOTE) begin
          scan_held  = (b == CH_N) ? CH_NEWLINE : (b == CH_T) ? CH_TAB : b;
          scan_state = MODE_CLOSE;
        end else begin
          done = 1'b1;
          st   = ST_UNKNOWN_ESC;
        end
      end
      MODE_HEX1: begin
        if (eoi || !is_hex(b)) begin
          done = 1'b1;
          st   = ST_BAD_HEX;
        end else begin
          scan_held  = {4'h0, hex_nibble(b)};
          scan_state = MODE_HEX2;
        end
      end
      MODE_HEX2, MODE_CLOSE: begin
        // After one hex digit a non-hex byte is handled as the byte after the character.
        if (scan_state == MODE_HEX2 && !eoi && is_hex(b)) begin
          scan_held  = {scan_held[3:0], hex_nibble(b)};
          scan_state = MODE_CLOSE;
        end else if (eoi) begin
          done = 1'b1;
          st   = ST_NO_CLOSE;
        end else if (b == CH_QUOTE) begin
          done = 1'b1;
          st   = ST_OK;
        end else begin
          scan_state = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (eoi || b == CH_QUOTE) begin
          done = 1'b1;
          st   = ST_MULTICHAR;
        end
      end
      default: begin
        if (!eoi && b == CH_QUOTE) begin
          scan_state = MODE_OPEN;
          scan_held  = 8'h00;
        end else begin
          scan_state = MODE_IDLE;
        end
      end
    endcase
    if (done) begin
      res.status     = st;
      res.char_value = (st == ST_OK) ? scan_held : 8'h00;
      scan_state     = MODE_IDLE;
      scan_held      = 8'h00;
    end
    return done;
  endfunction

  // Offers one request in bursts with random gaps, then records what it should produce.
  task automatic send_req(input cls_req_t r, input bit typed = 1'b0,
                          input cls_rsp_t typed_rsp = '0);
    cls_rsp_t got;
    bit       hit;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    req_count++;
    if (scan_state != MODE_IDLE || (!r.end_of_input && r.data_byte == CH_QUOTE)) live_items++;
    hit = scan_literal(r, got);
    if (typed) literal_q = {literal_q, typed_rsp};
    else if (hit) literal_q = {literal_q, got};
  endtask

  task automatic add_row(input logic [7:0] b, input logic eoi, input bit typed = 1'b0,
                         input logic [2:0] st = ST_OK, input logic [7:0] val = 8'h00);
    dir_row_t row;
    row.req            = mk_req(b, eoi);
    row.typed          = typed;
    row.rsp.status     = st;
    row.rsp.char_value = val;
    dir_rows = {dir_rows, row};
  endtask

  // Mostly well-formed literals with random content; the rest are errors and raw noise.
  task automatic send_literal();
    int         pick;
    int         n;
    logic [7:0] b;
    bit         closed;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) send_req(mk_req(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
      return;
    end
    send_req(mk_req(CH_QUOTE, 1'b0));
    closed = 1'b0;
    if (pick < 14) begin
      closed = 1'b1;
      send_req(mk_req(CH_QUOTE, 1'b0));
    end else if (pick < 17) begin
      closed = 1'b1;
      send_req(mk_req(8'($urandom_range(0, 255)), 1'b1));
    end else if (pick < 45) begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (b == CH_QUOTE || b == CH_BACKSLASH);
      send_req(mk_req(b, 1'b0));
    end else begin
      send_req(mk_req(CH_BACKSLASH, 1'b0));
      if (pick < 62) begin
        case ($urandom_range(0, 3))
          0: b = CH_N;
          1: b = CH_T;
          2: b = CH_BACKSLASH;
          default: b = CH_QUOTE;
        endcase
        send_req(mk_req(b, 1'b0));
      end else if (pick < 84) begin
        send_req(mk_req(CH_X, 1'b0));
        send_req(mk_req(rand_hex(), 1'b0));
        if (pick < 76) send_req(mk_req(rand_hex(), 1'b0));
      end else begin
        closed = 1'b1;
        case ($urandom_range(0, 3))
          0: send_req(mk_req(8'($urandom_range(0, 255)), 1'b1));
          1: begin
            do begin
              b = 8'($urandom_range(0, 255));
            end while (b == CH_N || b == CH_T || b == CH_BACKSLASH || b == CH_QUOTE ||
                       b == CH_X);
            send_req(mk_req(b, 1'b0));
          end
          2: begin
            send_req(mk_req(CH_X, 1'b0));
            do begin
              b = 8'($urandom_range(0, 255));
            end while (is_hex(b));
            send_req(mk_req(b, 1'b0));
          end
          default: begin
            send_req(mk_req(CH_X, 1'b0));
            send_req(mk_req(8'($urandom_range(0, 255)), 1'b1));
          end
        endcase
      end
    end
    if (!closed) begin
      pick = $urandom_range(0, 99);
      if (pick >= 88) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          do begin
            b = 8'($urandom_range(0, 255));
          end while (b == CH_QUOTE);
          send_req(mk_req(b, 1'b0));
        end
      end
      if (pick < 78 || (pick >= 88 && $urandom_range(0, 3) != 0))
        send_req(mk_req(CH_QUOTE, 1'b0));
      else
        send_req(mk_req(8'($urandom_range(0, 255)), 1'b1));
    end
  endtask

  initial begin : result_drain
    int       pat_mode;
    int       pat_left;
    int       hold_left;
    bit       pressed;
    cls_rsp_t want;
    pat_mode  = 0;
    pat_left  = 40;
    hold_left = 0;
    pressed   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        status_seen[out_rsp_o.status]++;
        if (literal_q.size() == 0) begin
          $error("unexpected result: status %0d char_value 0x%02h",
                 out_rsp_o.status, out_rsp_o.char_value);
          err_count++;
        end else begin
          want = literal_q.pop_front();
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_rsp_o.status);
            err_count++;
          end
          if (out_rsp_o.char_value !== want.char_value) begin
            $error("char_value: expected 0x%02h, actual 0x%02h",
                   want.char_value, out_rsp_o.char_value);
            err_count++;
          end
        end
      end
      // One long hold-off lets the result register fill and back up the request side.
      if (!pressed && results_seen >= 60) begin
        pressed   = 1'b1;
        hold_left = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(10, 120);
        end
        pat_left--;
        case (pat_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL char_literal_scanner_core");
    $finish;
  end

  initial begin
    int kinds;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(8'h00, 1'b1);
    add_row(CH_QUOTE, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, ST_UNTERMINATED);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_QUOTE, 1'b0, 1'b1, ST_EMPTY);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, ST_INCOMPLETE);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(8'h71, 1'b0, 1'b1, ST_UNKNOWN_ESC);
    // The quote that breaks the hex escape is consumed and does not open a literal.
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_X, 1'b0);
    add_row(CH_QUOTE, 1'b0, 1'b1, ST_BAD_HEX);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_X, 1'b0);
    add_row(8'h46, 1'b0);
    add_row(8'h66, 1'b0);
    add_row(CH_QUOTE, 1'b0, 1'b1, ST_OK, 8'hFF);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_X, 1'b0);
    add_row(8'h37, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, ST_NO_CLOSE);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_N, 1'b0);
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_QUOTE, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, ST_MULTICHAR);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    while (live_items < LiveItemTarget) send_literal();
    in_valid_i <= 1'b0;

    for (int i = 0; i < 20000 && literal_q.size() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (literal_q.size() != 0) begin
      $error("%0d expected results never arrived", literal_q.size());
      err_count++;
    end

    kinds = 0;
    foreach (status_seen[s]) if (status_seen[s] > 0) kinds++;
    $display("Sent %0d requests in random bursts and checked %0d results,",
             req_count, results_seen);
    $display("with a %0d-cycle stall; saw %0d of 8 status kinds, %0d literals decoded cleanly.",
             StallCycles, kinds, status_seen[ST_OK]);
    if (err_count == 0) begin
      $display("PASS char_literal_scanner_core");
    end else begin
      $display("FAIL char_literal_scanner_core");
    end
    $finish;
  end

endmodule
